// ----- src/cfrd_pkg.sv -----
// Package for the COBS frame receiver: result item type, kind and cause codes,
// and configuration register indexes. No dependencies.
`default_nettype none

package cfrd_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_FRAME_LEN = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT_TICKS = 8'd1;

    localparam logic [7:0]  MAX_FRAME_LEN_RESET = 8'd114;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;

    localparam logic [7:0] BYTE_DELIM     = 8'h00;
    localparam logic [7:0] CODE_FULL      = 8'hFF;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic CAUSE_OVERFLOW = 1'b0;
    localparam logic CAUSE_TIMEOUT  = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       truncated;
        logic       abort_cause;
    } result_t;

endpackage

`default_nettype wire

// ----- src/cfrd_core.sv -----
// Per-item decoder of the COBS frame receiver: frame state registers and the
// combinational step logic. Depends on cfrd_pkg.
`default_nettype none

module cfrd_core
    import cfrd_pkg::*;
#(
    parameter int IDLE_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic        cmd,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  max_frame_len,
    input  wire logic [15:0] timeout_ticks,
    output logic             res_valid,
    output result_t          res
);

    localparam int CMP_WIDTH = (IDLE_WIDTH > 16) ? IDLE_WIDTH : 16;

    logic [7:0]            frame_count_reg, frame_count_next;
    logic [7:0]            group_left_reg, group_left_next;
    logic                  prev_full_reg, prev_full_next;
    logic [IDLE_WIDTH-1:0] idle_count_reg, idle_count_next;
    logic [IDLE_WIDTH-1:0] idle_inc;

    always_comb
    begin
        frame_count_next = frame_count_reg;
        group_left_next  = group_left_reg;
        prev_full_next   = prev_full_reg;
        idle_count_next  = idle_count_reg;
        res_valid        = 1'b0;
        res              = '0;
        res.kind         = KIND_DATA;

        // The idle counter saturates rather than wrapping.
        idle_inc = (idle_count_reg == '1) ? idle_count_reg : idle_count_reg + 1'b1;

        if (cmd == CMD_TICK)
        begin
            idle_count_next = idle_inc;
            if (frame_count_reg != 8'd0 &&
                CMP_WIDTH'(idle_inc) > CMP_WIDTH'(timeout_ticks))
            begin
                frame_count_next = '0;
                group_left_next  = '0;
                prev_full_next   = 1'b0;
                res_valid        = 1'b1;
                res.kind         = KIND_ABORT;
                res.abort_cause  = CAUSE_TIMEOUT;
            end
        end
        else
        begin
            idle_count_next = '0;
            if (rx_byte == BYTE_DELIM)
            begin
                // An empty frame ends silently.
                if (frame_count_reg != 8'd0)
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_END;
                    res.truncated = (group_left_reg != 8'd0);
                end
                frame_count_next = '0;
                group_left_next  = '0;
                prev_full_next   = 1'b0;
            end
            else if (frame_count_reg >= max_frame_len)
            begin
                frame_count_next = '0;
                group_left_next  = '0;
                prev_full_next   = 1'b0;
                res_valid        = 1'b1;
                res.kind         = KIND_ABORT;
                res.abort_cause  = CAUSE_OVERFLOW;
            end
            else if (group_left_reg != 8'd0)
            begin
                frame_count_next = frame_count_reg + 8'd1;
                group_left_next  = group_left_reg - 8'd1;
                res_valid        = 1'b1;
                res.kind         = KIND_DATA;
                res.data         = rx_byte;
            end
            else
            begin
                // Code byte: a zero goes out first unless this is the first
                // group or the previous group was a full one.
                frame_count_next = frame_count_reg + 8'd1;
                group_left_next  = rx_byte - 8'd1;
                prev_full_next   = (rx_byte == CODE_FULL);
                if (frame_count_reg != 8'd0 && !prev_full_reg)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_DATA;
                    res.data  = BYTE_DELIM;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
            group_left_reg  <= '0;
            prev_full_reg   <= 1'b0;
            idle_count_reg  <= '0;
        end
        else if (step)
        begin
            frame_count_reg <= frame_count_next;
            group_left_reg  <= group_left_next;
            prev_full_reg   <= prev_full_next;
            idle_count_reg  <= idle_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/cobs_frame_receiver_decoder.sv -----
// Top level of the COBS frame receiver: configuration registers, decoder core
// and a two-entry output register with skid. Depends on cfrd_pkg, cfrd_core.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+-------------------------------------
//   in      | in_valid / in_stall      | cmd, rx_byte
//   out     | out_valid / out_stall    | kind, out_byte, truncated, abort_cause
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// The decoder step is combinational between the input port and the output
// register: an item can be accepted on every clock edge unless the skid is full,
// and its result is registered in the output or, on a stall, the skid register.
// Reset clears the frame state, the idle counter and the output valid flags,
// and loads the configuration defaults (frame limit 114, timeout 100 ticks).
// A stalled result is held in the output register while the next item is
// accepted into the skid register; input stalls only once the skid is full.
`default_nettype none

module cobs_frame_receiver_decoder
    import cfrd_pkg::*;
#(
    parameter int IDLE_WIDTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       cmd,
    input  wire logic [7:0]                 rx_byte,

    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      kind,
    output logic [7:0]                      out_byte,
    output logic                            truncated,
    output logic                            abort_cause,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [7:0]  max_frame_len_reg;
    logic [15:0] timeout_ticks_reg;

    logic    accept;
    logic    take;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    // Always writable. User keeps block idle whenever it is used; unenforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg <= MAX_FRAME_LEN_RESET;
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // The input is held off only while the skid register holds a result.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && !out_stall;

    cfrd_core #(
        .IDLE_WIDTH (IDLE_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .cmd           (cmd),
        .rx_byte       (rx_byte),
        .max_frame_len (max_frame_len_reg),
        .timeout_ticks (timeout_ticks_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Valid flags of the output and skid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // No item is accepted here; the skid moves up once the output drains.
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_valid_reg && !take)
        begin
            if (accept && res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            out_valid_reg <= accept && res_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (out_valid_reg && !take)
        begin
            if (accept && res_valid)
            begin
                skid_reg <= res;
            end
        end
        else if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign out_byte    = out_reg.data;
    assign truncated   = out_reg.truncated;
    assign abort_cause = out_reg.abort_cause;

endmodule

`default_nettype wire
